@@ sv/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies.
package uer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DISC  = 2'd2
  } status_t;

  localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_TRIG_TICKS   = 2'd1;
  localparam logic [1:0] REG_MIN_RANGE    = 2'd2;
  localparam logic [1:0] REG_MAX_RANGE    = 2'd3;

  localparam int CFG_DATA_W  = 17;
  localparam int DIST_W      = 17;
  localparam int SCALE_MUL   = 1756;
  localparam int SCALE_W     = 11;
  localparam int SCALE_SHIFT = 10;
  localparam int CMP_W       = 33;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [15:0]       echo_timeout_us;
    logic [7:0]        trigger_ticks;
    logic [DIST_W-1:0] min_range;
    logic [DIST_W-1:0] max_range;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    status_t           status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

@@ sv/uer_cfg.sv @@
// Configuration register bank of the ultrasonic echo ranger.
// Depends on uer_pkg.
module uer_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  output uer_pkg::cfg_t                  cfg
);
  import uer_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_timeout_us <= 16'd38000;
      cfg.trigger_ticks   <= 8'd10;
      cfg.min_range       <= DIST_W'(200);
      cfg.max_range       <= DIST_W'(40000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ECHO_TIMEOUT: cfg.echo_timeout_us <= cfg_data[15:0];
        REG_TRIG_TICKS:   cfg.trigger_ticks   <= cfg_data[7:0];
        REG_MIN_RANGE:    cfg.min_range       <= cfg_data[DIST_W-1:0];
        REG_MAX_RANGE:    cfg.max_range       <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/uer_step.sv @@
// Phase sequencer, tick counter and distance scaling for one tick item.
// Depends on uer_pkg.
module uer_step #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          start_req,
  input  logic          echo_level,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);
  import uer_pkg::*;

  localparam int W  = TICK_COUNT_BITS;
  localparam int PW = W + SCALE_W;

  phase_t         phase, phase_next;
  logic [W-1:0]   tick_count, tick_count_next;
  logic [W-1:0]   count_inc;
  logic [PW-1:0]  prod;
  logic [CMP_W-1:0] full;
  logic           timed_out, trig_end, out_of_range;

  assign count_inc = (&tick_count) ? tick_count : tick_count + W'(1);
  assign timed_out = CMP_W'(count_inc) > CMP_W'(cfg.echo_timeout_us);
  assign trig_end  = CMP_W'(tick_count) >= CMP_W'(cfg.trigger_ticks);
  assign prod      = PW'(tick_count) * PW'(SCALE_MUL);
  assign full      = CMP_W'(prod >> SCALE_SHIFT);
  assign out_of_range = (full < CMP_W'(cfg.min_range)) || (full > CMP_W'(cfg.max_range));

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next      = PH_TRIG;
          tick_count_next = W'(1);
        end
      end
      PH_TRIG: begin
        if (trig_end) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          phase_next      = PH_MEAS;
          tick_count_next = W'(1);
        end else if (timed_out) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
        end
      end
      PH_MEAS: begin
        if (!echo_level || timed_out) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.trigger_level = 1'b0;
    res.done_res      = 1'b0;
    res.status        = ST_OK;
    res.distance      = '0;
    unique case (phase)
      PH_IDLE: res.trigger_level = start_req;
      PH_TRIG: res.trigger_level = !trig_end;
      PH_WAIT: begin
        if (!echo_level && timed_out) begin
          res.done_res = 1'b1;
          res.status   = ST_DISC;
        end
      end
      PH_MEAS: begin
        if (!echo_level) begin
          res.done_res = 1'b1;
          res.status   = out_of_range ? ST_RANGE : ST_OK;
          res.distance = (full > CMP_W'(DIST_MAX)) ? DIST_MAX : full[DIST_W-1:0];
        end else if (timed_out) begin
          res.done_res = 1'b1;
          res.status   = ST_DISC;
        end
      end
      default: ;
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (adv) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

@@ sv/ultrasonic_echo_ranger_core.sv @@
// Top level of the ultrasonic echo ranger: input register, step logic, result register.
// Depends on uer_pkg, uer_cfg and uer_step.
//
// Each input item is one 1 us tick (start request plus sampled echo level) and
// yields exactly one result item. One item is taken every clock unless the
// result register is stalled by out_ready; an item passes through the input
// register and then the result register. The per-tick work is a single pass
// through the phase sequencer and one TICK_COUNT_BITS x 11 multiply for the
// distance, between the input register and the result register. The input register
// can take one new item while the previous result still waits for out_ready.
module ultrasonic_echo_ranger_core #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           start_req,
  input  logic                           echo_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           trigger_level,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [1:0]                     status,
  output logic [uer_pkg::DIST_W-1:0]     distance,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res_comb, res_q;
  logic in_q_valid, start_q, echo_q, adv;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_step #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .start_req  (start_q),
    .echo_level (echo_q),
    .cfg        (cfg),
    .res        (res_comb)
  );

  assign adv      = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) in_q_valid <= in_valid;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_q <= start_req;
      echo_q  <= echo_level;
    end
    if (adv) res_q <= res_comb;
  end

  assign trigger_level = res_q.trigger_level;
  assign busy_res      = res_q.busy_res;
  assign done_res      = res_q.done_res;
  assign status        = res_q.status;
  assign distance      = res_q.distance;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.done_res |-> !res_q.busy_res && !res_q.trigger_level)
    else $error("finished item still busy or triggering");

  a_disc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.status == ST_DISC |-> res_q.distance == '0 && res_q.done_res)
    else $error("disconnected item carries a distance");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_q.done_res |-> res_q.status == ST_OK && res_q.distance == '0)
    else $error("status or distance set without done");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("result changed while stalled");

endmodule

@@ tb/ultrasonic_echo_ranger_core_test.sv @@
// Testbench for ultrasonic_echo_ranger_core: drives 1 us ticks, predicts every result item
// with its own tick-by-tick ranger model and checks each one field by field.
// Depends on uer_pkg and ultrasonic_echo_ranger_core.
module ultrasonic_echo_ranger_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int CNT_W = 16;
  localparam int RANDOM_ITEMS = 600;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic start_req;
  logic echo_level;
  logic out_valid;
  logic out_ready;
  logic trigger_level;
  logic busy_res;
  logic done_res;
  logic [1:0] status;
  logic [DIST_W-1:0] distance;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t rng_cfg;
  phase_t rng_phase;
  logic [CNT_W-1:0] rng_count;
  res_t due_results[$];

  int errors = 0;
  int ranging_items = 0;
  int stall_left;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  ultrasonic_echo_ranger_core #(
    .TICK_COUNT_BITS(CNT_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_req(start_req),
    .echo_level(echo_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trigger_level(trigger_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .status(status),
    .distance(distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("ultrasonic_echo_ranger_core verification failed");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(99));
    if (r < 70) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic void bump_count();
    if (rng_count != '1) rng_count = rng_count + CNT_W'(1);
  endfunction

  // one tick of the ranger: advances phase and counter, returns the result item
  function automatic res_t step_ranger(input logic start, input logic echo);
    res_t r;
    logic [CMP_W-1:0] full;
    r = '0;
    full = '0;
    case (rng_phase)
      PH_IDLE: begin
        if (start) begin
          rng_phase = PH_TRIG;
          rng_count = CNT_W'(1);
          r.trigger_level = 1'b1;
        end
      end
      PH_TRIG: begin
        if (rng_count >= CNT_W'(rng_cfg.trigger_ticks)) begin
          rng_phase = PH_WAIT;
          rng_count = '0;
        end else begin
          bump_count();
          r.trigger_level = 1'b1;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          rng_phase = PH_MEAS;
          rng_count = CNT_W'(1);
        end else begin
          bump_count();
          if (rng_count > rng_cfg.echo_timeout_us) begin
            rng_phase = PH_IDLE;
            rng_count = '0;
            r.done_res = 1'b1;
            r.status = ST_DISC;
          end
        end
      end
      default: begin
        if (echo) begin
          bump_count();
          if (rng_count > rng_cfg.echo_timeout_us) begin
            rng_phase = PH_IDLE;
            rng_count = '0;
            r.done_res = 1'b1;
            r.status = ST_DISC;
          end
        end else begin
          full = (CMP_W'(rng_count) * CMP_W'(SCALE_MUL)) >> SCALE_SHIFT;
          if (full < CMP_W'(rng_cfg.min_range) || full > CMP_W'(rng_cfg.max_range)) begin
            r.status = ST_RANGE;
          end else begin
            r.status = ST_OK;
          end
          r.distance = (full > CMP_W'(DIST_MAX)) ? DIST_MAX : full[DIST_W-1:0];
          rng_phase = PH_IDLE;
          rng_count = '0;
          r.done_res = 1'b1;
        end
      end
    endcase
    r.busy_res = (rng_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // result side: random stalls, each accepted item checked against the oldest prediction
  initial begin
    res_t want;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual done %0b status %0d dist %0d",
                   $time, done_res, status, distance);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("trigger_level", 32'(want.trigger_level), 32'(trigger_level));
          check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
          check_field("done_res", 32'(want.done_res), 32'(done_res));
          check_field("status", 32'(want.status), 32'(status));
          check_field("distance", 32'(want.distance), 32'(distance));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = stalls_on ? pick_gap() : 0;
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= start;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    if (rng_phase != PH_IDLE || start) ranging_items++;
    due_results.push_back(step_ranger(start, echo));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ECHO_TIMEOUT: rng_cfg.echo_timeout_us = data[15:0];
      REG_TRIG_TICKS:   rng_cfg.trigger_ticks = data[7:0];
      REG_MIN_RANGE:    rng_cfg.min_range = data;
      default:          rng_cfg.max_range = data;
    endcase
  endtask

  // finish any measurement in progress, let every result out, then write all registers
  task automatic set_config(input logic [15:0] timeout, input logic [7:0] trig,
                            input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
    while (rng_phase != PH_IDLE) send_tick(1'b0, rng_phase == PH_WAIT);
    wait_results_drained();
    write_reg(REG_ECHO_TIMEOUT, CFG_DATA_W'(timeout));
    write_reg(REG_TRIG_TICKS, CFG_DATA_W'(trig));
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    cfg_valid <= 1'b0;
  endtask

  // start, trigger, echo wait of wait_len low ticks, pulse of pulse_len high ticks;
  // start requests while busy are random and must be ignored
  task automatic run_measurement(input int idle_noise, input int wait_len, input int pulse_len);
    int n;
    repeat (idle_noise) send_tick(1'b0, 1'($urandom_range(1)));
    send_tick(1'b1, 1'($urandom_range(1)));
    while (rng_phase == PH_TRIG) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    n = 0;
    while (rng_phase == PH_WAIT && n < wait_len) begin
      send_tick(1'($urandom_range(1)), 1'b0);
      n++;
    end
    if (rng_phase == PH_WAIT) send_tick(1'($urandom_range(1)), 1'b1);
    n = 1;
    while (rng_phase == PH_MEAS && n < pulse_len) begin
      send_tick(1'($urandom_range(1)), 1'b1);
      n++;
    end
    if (rng_phase == PH_MEAS) send_tick(1'($urandom_range(1)), 1'b0);
  endtask

  function automatic int pick_wait();
    int t;
    t = int'(rng_cfg.echo_timeout_us);
    case ($urandom_range(3))
      0: if (t <= 60) return t + int'($urandom_range(1));
      1: return 0;
      default: ;
    endcase
    return int'($urandom_range(1, 12));
  endfunction

  // pulse lengths that land on either side of the range limits and the timeout
  function automatic int pick_pulse();
    int lo_edge;
    int hi_edge;
    int t;
    lo_edge = (int'(rng_cfg.min_range) * (1 << SCALE_SHIFT) + SCALE_MUL - 1) / SCALE_MUL;
    hi_edge = ((int'(rng_cfg.max_range) + 1) * (1 << SCALE_SHIFT) - 1) / SCALE_MUL;
    t = int'(rng_cfg.echo_timeout_us);
    case ($urandom_range(5))
      0: if (lo_edge <= 150) return (lo_edge > 1 ? lo_edge - 1 : 1) + int'($urandom_range(2));
      1: if (hi_edge <= 150) return hi_edge + int'($urandom_range(1));
      2: if (t <= 60) return t + int'($urandom_range(1));
      3: return int'($urandom_range(1, 4));
      default: ;
    endcase
    return int'($urandom_range(1, 40));
  endfunction

  // reset register values, distances either side of the default lower limit
  task automatic test_reset_config();
    run_measurement(2, 3, 117);
    run_measurement(0, 0, 116);
  endtask

  task automatic test_directed_edges();
    set_config(16'd3, 8'd1, '0, DIST_MAX);
    // shortest measurement, start on the finishing tick ignored
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    // echo never rises
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // echo stays high too long
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    // zero trigger length acts as one, crossed limits
    set_config(16'd3, 8'd0, DIST_MAX, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_random_phases();
    int target;
    int phase_end;
    int k;
    logic [15:0] t;
    logic [7:0] tr;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    target = ranging_items + RANDOM_ITEMS;
    k = 0;
    while (ranging_items < target) begin
      case (k)
        0: set_config(16'd1, 8'd1, '0, DIST_MAX);
        1: set_config(16'hFFFF, 8'hFF, DIST_MAX, '0);
        default: begin
          case ($urandom_range(7))
            0: t = 16'd1;
            1: t = 16'hFFFF;
            2: t = 16'd38000;
            default: t = 16'($urandom_range(2, 40));
          endcase
          tr = ($urandom_range(15) == 0) ? 8'hFF : 8'($urandom_range(1, 6));
          case ($urandom_range(5))
            0: begin
              lo = '0;
              hi = DIST_MAX;
            end
            1: begin
              lo = DIST_W'($urandom_range(50, DIST_MAX));
              hi = DIST_W'($urandom_range(0, int'(lo) - 1));
            end
            2: begin
              lo = DIST_W'($urandom_range(0, 60));
              hi = lo;
            end
            default: begin
              lo = DIST_W'($urandom_range(0, 40));
              hi = lo + DIST_W'($urandom_range(0, 60));
            end
          endcase
          set_config(t, tr, lo, hi);
        end
      endcase
      gaps_on = ($urandom_range(3) != 0);
      stalls_on = ($urandom_range(3) != 0);
      phase_end = ranging_items + int'($urandom_range(60, 150));
      while (ranging_items < phase_end) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 16))
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          run_measurement(($urandom_range(3) == 0) ? int'($urandom_range(1, 3)) : 0,
                          pick_wait(), pick_pulse());
        end
      end
      k++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    start_req = 1'b0;
    echo_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ECHO_TIMEOUT;
    cfg_data = '0;
    rng_cfg = '{echo_timeout_us: 16'd38000, trigger_ticks: 8'd10,
                min_range: 17'd200, max_range: 17'd40000};
    rng_phase = PH_IDLE;
    rng_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_directed_edges();
    test_random_phases();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger_core verification clean");
    end else begin
      $display("ultrasonic_echo_ranger_core verification failed");
    end
    $finish;
  end

endmodule

@@ ultrasonic_echo_ranger_core.f @@
sv/uer_pkg.sv
sv/uer_cfg.sv
sv/uer_step.sv
sv/ultrasonic_echo_ranger_core.sv
tb/ultrasonic_echo_ranger_core_test.sv
